FILE: rtl/core/asfap_pkg.sv
// ============================================================================
// asfap_pkg
// Shared types, constants and helpers for the audio sample ring buffer with
// frame-timed packet output.
// ============================================================================
package asfap_pkg;

    // Buffer geometry
    localparam int BUFFER_DEPTH = 512;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);

    // Number of all-zero pairs dropped after reset (the first ones seen)
    localparam logic [7:0] ZERO_SKIP = 8'd2;

    // Configuration reset values
    localparam logic [5:0] NOMINAL_LEN_RST = 6'd47;
    localparam logic [9:0] BACKLOG_RST     = 10'd141;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] CFG_MUTE    = 2'd0;
    localparam logic [1:0] CFG_NOMINAL = 2'd1;
    localparam logic [1:0] CFG_BACKLOG = 2'd2;

    // Request commands
    localparam logic [1:0] CMD_PAIR = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_STAT = 2'd2;

    // Result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] sample_first;
        logic [15:0] sample_second;
        logic        capture_on;
        logic        host_ready;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample;
        logic        last;
        logic [9:0]  fill_level;
        logic        overflow_seen;
        logic [15:0] underrun_count;
    } out_item_t;

    // Classified operation passed from front to back
    typedef enum logic [1:0] {
        OP_PAIR,
        OP_TICK,
        OP_STAT
    } op_code_t;

    typedef struct packed {
        op_code_t    code;
        logic        zero_pair;
        logic [15:0] first;
        logic [15:0] second;
    } op_t;

    typedef struct packed {
        logic       mute;
        logic [5:0] nominal_len;
        logic [9:0] backlog;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WR2,
        BK_PKT
    } bk_state_t;

    // Ring pointer advance with wrap at the buffer depth
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(BUFFER_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    // Fill count as reported (low 10 bits)
    function automatic logic [9:0] to_level(input logic [FILL_W-1:0] fill);
        logic [31:0] w;
        w = 32'(fill);
        return w[9:0];
    endfunction

endpackage

FILE: rtl/core/asfap_front.sv
// ============================================================================
// asfap_front
// Request intake: accepts requests, drops those that have no effect and
// classifies the rest into operations for the back end.
// ============================================================================
module asfap_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  asfap_pkg::in_item_t s_data,
    input  logic                q_full,
    output logic                q_push,
    output asfap_pkg::op_t      q_op
);

    logic keep;

    // Accept whenever the operation queue has room
    assign s_ready = !q_full;

    // Classify the request
    always_comb begin
        keep      = 1'b0;
        q_op.code = asfap_pkg::OP_PAIR;
        unique case (s_data.cmd)
            asfap_pkg::CMD_PAIR: begin
                keep      = s_data.capture_on;
                q_op.code = asfap_pkg::OP_PAIR;
            end
            asfap_pkg::CMD_TICK: begin
                keep      = s_data.host_ready;
                q_op.code = asfap_pkg::OP_TICK;
            end
            asfap_pkg::CMD_STAT: begin
                keep      = 1'b1;
                q_op.code = asfap_pkg::OP_STAT;
            end
            default: begin
                keep      = 1'b0;
                q_op.code = asfap_pkg::OP_PAIR;
            end
        endcase
        q_op.zero_pair = (s_data.sample_first == 16'd0) && (s_data.sample_second == 16'd0);
        q_op.first     = s_data.sample_first;
        q_op.second    = s_data.sample_second;
    end

    assign q_push = s_valid && s_ready && keep;

endmodule

FILE: rtl/core/asfap_cmd_queue.sv
// ============================================================================
// asfap_cmd_queue
// Two-entry operation queue between the intake and the buffer engine.
// ============================================================================
module asfap_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  asfap_pkg::op_t push_op,
    output logic           full,
    output logic           valid,
    output asfap_pkg::op_t head,
    input  logic           pop
);

    asfap_pkg::op_t q0_reg;
    asfap_pkg::op_t q1_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic [1:0]     cnt_after_pop;
    logic           do_pop;

    assign valid  = (cnt_reg != 2'd0);
    assign full   = (cnt_reg == 2'd2);
    assign head   = q0_reg;
    assign do_pop = pop && valid;

    assign cnt_after_pop = cnt_reg - {1'b0, do_pop};
    assign cnt_next      = cnt_after_pop + {1'b0, push};

    // Occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Entries: shift on pop, write behind the remaining entries
    always_ff @(posedge aclk) begin
        if (push && (cnt_after_pop == 2'd0)) begin
            q0_reg <= push_op;
        end else if (do_pop) begin
            q0_reg <= q1_reg;
        end
        if (push && (cnt_after_pop != 2'd0)) begin
            q1_reg <= push_op;
        end
    end

endmodule

FILE: rtl/core/asfap_back.sv
// ============================================================================
// asfap_back
// Buffer engine: owns the sample ring, fill and status counters, runs one
// operation at a time and streams packet samples into a two-entry output
// queue, one sample per cycle while that queue has room.
// ============================================================================
module asfap_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  asfap_pkg::cfg_t      cfg,
    input  logic                 q_valid,
    input  asfap_pkg::op_t       q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output asfap_pkg::out_item_t m_data
);

    localparam int IDX_W  = asfap_pkg::IDX_W;
    localparam int FILL_W = asfap_pkg::FILL_W;

    // Sample ring
    logic [15:0] mem [asfap_pkg::BUFFER_DEPTH];
    logic [15:0] ram_q;

    // Engine state
    asfap_pkg::bk_state_t state_reg, state_next;
    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        skip_reg, skip_next;
    logic              ovf_reg, ovf_next;
    logic [15:0]       und_reg, und_next;
    logic [15:0]       second_reg, second_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;

    // Output queue
    asfap_pkg::out_item_t oq0_reg, oq1_reg;
    logic [1:0]           ocnt_reg;
    logic [1:0]           ocnt_after_pop;
    logic                 out_pop;
    logic                 out_push;
    asfap_pkg::out_item_t out_data;
    logic [1:0]           occ;

    // Memory controls
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [15:0]       mem_wdata;
    logic              rd_en;

    // Packet length
    logic [6:0]        len_nom;
    logic [6:0]        len;
    logic              stat_go;

    assign m_valid        = (ocnt_reg != 2'd0);
    assign m_data         = oq0_reg;
    assign out_pop        = m_valid && m_ready;
    assign ocnt_after_pop = ocnt_reg - {1'b0, out_pop};
    // Slots taken once the pending read lands
    assign occ            = ocnt_after_pop + {1'b0, pend_reg};

    // Packet length for a tick: nominal, plus one above backlog, capped at fill
    always_comb begin
        len_nom = {1'b0, cfg.nominal_len} + {6'd0, (fill_reg > FILL_W'(cfg.backlog))};
        if (FILL_W'(len_nom) > fill_reg) begin
            len = 7'(fill_reg);
        end else begin
            len = len_nom;
        end
    end

    // Next state and controls
    always_comb begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        ridx_next      = ridx_reg;
        fill_next      = fill_reg;
        skip_next      = skip_reg;
        ovf_next       = ovf_reg;
        und_next       = und_reg;
        second_next    = second_reg;
        cnt_next       = cnt_reg;
        pend_last_next = pend_last_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = widx_reg;
        mem_wdata      = q_head.first;
        rd_en          = 1'b0;
        stat_go        = 1'b0;

        unique case (state_reg)
            asfap_pkg::BK_IDLE: begin
                if (q_valid) begin
                    unique case (q_head.code)
                        asfap_pkg::OP_PAIR: begin
                            q_pop = 1'b1;
                            if (q_head.zero_pair && (skip_reg != 8'd0)) begin
                                skip_next = skip_reg - 8'd1;
                            end else if (fill_reg <
                                         FILL_W'(asfap_pkg::BUFFER_DEPTH - 2)) begin
                                mem_we      = 1'b1;
                                widx_next   = asfap_pkg::ring_next(widx_reg);
                                second_next = q_head.second;
                                fill_next   = fill_reg + FILL_W'(2);
                                state_next  = asfap_pkg::BK_WR2;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        asfap_pkg::OP_TICK: begin
                            q_pop = 1'b1;
                            if (fill_reg < FILL_W'(cfg.nominal_len)) begin
                                if (und_reg != 16'hFFFF) begin
                                    und_next = und_reg + 16'd1;
                                end
                            end else if (len != 7'd0) begin
                                cnt_next   = len;
                                fill_next  = fill_reg - FILL_W'(len);
                                state_next = asfap_pkg::BK_PKT;
                            end
                        end
                        asfap_pkg::OP_STAT: begin
                            // wait for packet data in flight and a free slot
                            if (!pend_reg && (occ < 2'd2)) begin
                                q_pop    = 1'b1;
                                stat_go  = 1'b1;
                                ovf_next = 1'b0;
                                und_next = 16'd0;
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            asfap_pkg::BK_WR2: begin
                mem_we     = 1'b1;
                mem_wdata  = second_reg;
                widx_next  = asfap_pkg::ring_next(widx_reg);
                state_next = asfap_pkg::BK_IDLE;
            end
            asfap_pkg::BK_PKT: begin
                if (occ < 2'd2) begin
                    rd_en          = 1'b1;
                    ridx_next      = asfap_pkg::ring_next(ridx_reg);
                    cnt_next       = cnt_reg - 7'd1;
                    pend_last_next = (cnt_reg == 7'd1);
                    if (cnt_reg == 7'd1) begin
                        state_next = asfap_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = asfap_pkg::BK_IDLE;
            end
        endcase
        pend_next = rd_en;
    end

    // Result to queue: landed packet sample or status report
    always_comb begin
        out_push                = pend_reg || stat_go;
        out_data.kind           = pend_reg ? asfap_pkg::KIND_SAMPLE : asfap_pkg::KIND_STATUS;
        out_data.sample         = (pend_reg && !cfg.mute) ? ram_q : 16'd0;
        out_data.last           = pend_reg ? pend_last_reg : 1'b1;
        out_data.fill_level     = asfap_pkg::to_level(fill_reg);
        out_data.overflow_seen  = ovf_reg;
        out_data.underrun_count = und_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= asfap_pkg::BK_IDLE;
            widx_reg      <= '0;
            ridx_reg      <= '0;
            fill_reg      <= '0;
            skip_reg      <= asfap_pkg::ZERO_SKIP;
            ovf_reg       <= 1'b0;
            und_reg       <= 16'd0;
            cnt_reg       <= 7'd0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            ocnt_reg      <= 2'd0;
        end else begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            ridx_reg      <= ridx_next;
            fill_reg      <= fill_next;
            skip_reg      <= skip_next;
            ovf_reg       <= ovf_next;
            und_reg       <= und_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            ocnt_reg      <= ocnt_after_pop + {1'b0, out_push};
        end
    end

    // Held second sample of a pair
    always_ff @(posedge aclk) begin
        second_reg <= second_next;
    end

    // Sample ring: one write, one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            ram_q <= mem[ridx_reg];
        end
    end

    // Output queue entries
    always_ff @(posedge aclk) begin
        if (out_push && (ocnt_after_pop == 2'd0)) begin
            oq0_reg <= out_data;
        end else if (out_pop) begin
            oq0_reg <= oq1_reg;
        end
        if (out_push && (ocnt_after_pop != 2'd0)) begin
            oq1_reg <= out_data;
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < FILL_W'(asfap_pkg::BUFFER_DEPTH))
        else $error("fill count beyond buffer depth");

    a_oq_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        out_push |-> (ocnt_after_pop < 2'd2))
        else $error("output queue written while full");

    a_pkt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == asfap_pkg::BK_PKT) |-> (cnt_reg != 7'd0))
        else $error("packet state with no samples left");

    a_status_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        stat_go |-> !pend_reg && (state_reg == asfap_pkg::BK_IDLE))
        else $error("status report overlaps packet data");

endmodule

FILE: rtl/core/audio_sample_fifo_adaptive_packets.sv
// ============================================================================
// audio_sample_fifo_adaptive_packets
// Audio sample ring buffer between a capture stream and frame-timed packets.
// ============================================================================
// s_* carries requests (sample pair, frame tick, status read-and-clear) and
// m_* carries results (packet samples or one status report), both valid/ready.
// The APB port holds mute, nominal packet length and backlog threshold at byte
// addresses 0, 4 and 8; write it only while idle. Requests pass a two-entry
// operation queue to the buffer engine. A pair is two writes on the single
// ring write port. A tick starts a packet read out sample by sample on the
// ring read port, holding while the result queue is full; its first sample
// passes the operation queue, engine state, ring read register and result
// queue to m_*. Status, underrun, skipped and overflowed pairs use no ring
// port; requests with no effect are dropped at intake.
// Reset empties the ring, clears the counters, reloads the zero-pair skip and
// restores register defaults; ring contents are not cleared. When m_ready is
// low the two-entry result queue fills, the engine holds on packets and status
// reports, then the operation queue fills and s_ready drops.
// ============================================================================
module audio_sample_fifo_adaptive_packets (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  asfap_pkg::in_item_t  s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output asfap_pkg::out_item_t m_data,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    asfap_pkg::cfg_t cfg_reg;
    logic            cfg_we;
    logic            q_full;
    logic            q_push;
    asfap_pkg::op_t  q_push_op;
    logic            q_valid;
    asfap_pkg::op_t  q_head;
    logic            q_pop;

    // Register access
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mute        <= 1'b0;
            cfg_reg.nominal_len <= asfap_pkg::NOMINAL_LEN_RST;
            cfg_reg.backlog     <= asfap_pkg::BACKLOG_RST;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                asfap_pkg::CFG_MUTE:    cfg_reg.mute        <= pwdata[0];
                asfap_pkg::CFG_NOMINAL: cfg_reg.nominal_len <= pwdata[5:0];
                asfap_pkg::CFG_BACKLOG: cfg_reg.backlog     <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            asfap_pkg::CFG_MUTE:    prdata = {31'd0, cfg_reg.mute};
            asfap_pkg::CFG_NOMINAL: prdata = {26'd0, cfg_reg.nominal_len};
            asfap_pkg::CFG_BACKLOG: prdata = {22'd0, cfg_reg.backlog};
            default:                prdata = 32'd0;
        endcase
    end

    // Intake and classification
    asfap_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_op    (q_push_op)
    );

    // Operation queue
    asfap_cmd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .valid   (q_valid),
        .head    (q_head),
        .pop     (q_pop)
    );

    // Buffer engine
    asfap_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
